### sv/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared widths, codes and pipeline control types for the height map sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

	// Fixed field widths of the request and response channels
	localparam int HEIGHT_W = 12;
	localparam int COORD_W  = 17;
	localparam int CELL_W   = 7;

	// Defaults for the top-level parameters
	localparam int MAP_DIM_DEF   = 128;
	localparam int FRAC_BITS_DEF = 8;

	// Four banks, indexed by {row parity, column parity}
	localparam int NUM_BANKS = 4;

	typedef enum logic {
		MODE_WRITE  = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	// Control carried along with a sample through the pipeline
	typedef struct packed {
		logic valid;
		logic in_range;
		logic odd_row;
		logic odd_col;
	} smp_ctl_t;

endpackage

### sv/hbs_req_if.sv
// ----------------------------------------------------------------------------
// hbs_req_if
// Request channel: cell writes and sample queries, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbs_req_if import hbs_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [CELL_W-1:0]          cell_row;
	logic [CELL_W-1:0]          cell_col;
	logic [HEIGHT_W-1:0]        cell_height;
	logic signed [COORD_W-1:0]  x_pos;
	logic signed [COORD_W-1:0]  y_pos;

	modport source (
		output valid, mode, cell_row, cell_col, cell_height, x_pos, y_pos,
		input  ready
	);

	modport sink (
		input  valid, mode, cell_row, cell_col, cell_height, x_pos, y_pos,
		output ready
	);
endinterface

### sv/hbs_rsp_if.sv
// ----------------------------------------------------------------------------
// hbs_rsp_if
// Response channel: interpolated height and range flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbs_rsp_if import hbs_pkg::*;;
	logic                valid;
	logic                ready;
	logic [HEIGHT_W-1:0] height;
	logic                in_range;

	modport source (
		output valid, height, in_range,
		input  ready
	);

	modport sink (
		input  valid, height, in_range,
		output ready
	);
endinterface

### sv/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hbs_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/hbs_fetch.sv
// ----------------------------------------------------------------------------
// hbs_fetch
// Range check, bank addressing and the four parity banks; stage 1 registers.
// ----------------------------------------------------------------------------
module hbs_fetch import hbs_pkg::*; #(
	parameter int MAP_DIM   = MAP_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       advance,
	input  logic                       mode,
	input  logic [CELL_W-1:0]          cell_row,
	input  logic [CELL_W-1:0]          cell_col,
	input  logic [HEIGHT_W-1:0]        cell_height,
	input  logic signed [COORD_W-1:0]  x_pos,
	input  logic signed [COORD_W-1:0]  y_pos,
	output smp_ctl_t                   ctl_s1,
	output logic [FRAC_BITS-1:0]       fx_s1,
	output logic [FRAC_BITS-1:0]       fy_s1,
	output logic [HEIGHT_W-1:0]        cells_s1 [NUM_BANKS]
);

	localparam int ROW_W  = $clog2(MAP_DIM);
	localparam int BANK_W = ROW_W - 1;
	localparam int ADDR_W = 2 * BANK_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int LIMIT  = (MAP_DIM - 1) << FRAC_BITS;

	logic signed [31:0] x_ext, y_ext;
	logic               in_range;
	logic [ROW_W-1:0]   ix, iy;
	logic [ROW_W:0]     ix_p1, iy_p1;
	logic [BANK_W-1:0]  row_even, row_odd, col_even, col_odd;
	logic [ADDR_W-1:0]  raddr [NUM_BANKS];

	logic [ROW_W-1:0]   wr_row, wr_col;
	logic               wr_ok;
	logic [1:0]         wr_bank;
	logic [ADDR_W-1:0]  waddr;

	// Sample coordinates: range check, integer and fraction parts
	assign x_ext    = 32'(x_pos);
	assign y_ext    = 32'(y_pos);
	assign in_range = (x_ext >= 0) && (x_ext < LIMIT) && (y_ext >= 0) && (y_ext < LIMIT);
	assign ix       = x_ext[FRAC_BITS +: ROW_W];
	assign iy       = y_ext[FRAC_BITS +: ROW_W];
	assign ix_p1    = {1'b0, ix} + (ROW_W+1)'(1);
	assign iy_p1    = {1'b0, iy} + (ROW_W+1)'(1);

	// Of the two rows (columns) touched, one is even and one odd
	assign row_even = iy_p1[BANK_W:1];
	assign row_odd  = iy[ROW_W-1:1];
	assign col_even = ix_p1[BANK_W:1];
	assign col_odd  = ix[ROW_W-1:1];

	assign raddr[0] = {row_even, col_even};
	assign raddr[1] = {row_even, col_odd};
	assign raddr[2] = {row_odd,  col_even};
	assign raddr[3] = {row_odd,  col_odd};

	// Cell write decode; writes outside the map are dropped
	assign wr_row  = ROW_W'(cell_row);
	assign wr_col  = ROW_W'(cell_col);
	assign wr_ok   = accept && (mode == MODE_WRITE)
		&& (32'(cell_row) < 32'(MAP_DIM)) && (32'(cell_col) < 32'(MAP_DIM));
	assign wr_bank = {wr_row[0], wr_col[0]};
	assign waddr   = {wr_row[ROW_W-1:1], wr_col[ROW_W-1:1]};

	// Parity banks: a sample reads one cell from each
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		hbs_ram #(
			.WIDTH (HEIGHT_W),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_ok && (wr_bank == 2'(b))),
			.waddr (waddr),
			.wdata (cell_height),
			.re    (advance),
			.raddr (raddr[b]),
			.rdata (cells_s1[b])
		);
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid    <= accept && (mode == MODE_SAMPLE);
			ctl_s1.in_range <= in_range;
			ctl_s1.odd_row  <= iy[0];
			ctl_s1.odd_col  <= ix[0];
		end
	end

	// Stage 1 fractions
	always_ff @(posedge clk) begin
		if (advance) begin
			fx_s1 <= x_ext[FRAC_BITS-1:0];
			fy_s1 <= y_ext[FRAC_BITS-1:0];
		end
	end

endmodule

### sv/hbs_interp.sv
// ----------------------------------------------------------------------------
// hbs_interp
// Bilinear blend: x pass on both rows, then y pass, then the output register.
// ----------------------------------------------------------------------------
module hbs_interp import hbs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smp_ctl_t             ctl_s1,
	input  logic [FRAC_BITS-1:0] fx_s1,
	input  logic [FRAC_BITS-1:0] fy_s1,
	input  logic [HEIGHT_W-1:0]  cells_s1 [NUM_BANKS],
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HEIGHT_W-1:0]  out_height,
	output logic                 out_in_range
);

	localparam int SUM_W = HEIGHT_W + FRAC_BITS + 2;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	// (a*(ONE-w) + b*w) >> FRAC_BITS, never above max(a, b)
	function automatic logic [HEIGHT_W-1:0] blend(
		input logic [HEIGHT_W-1:0]  a,
		input logic [HEIGHT_W-1:0]  b,
		input logic [FRAC_BITS-1:0] w
	);
		logic [FRAC_BITS:0] wc;
		logic [SUM_W-1:0]   sum;
		wc  = ONE - {1'b0, w};
		sum = SUM_W'(a) * SUM_W'(wc) + SUM_W'(b) * SUM_W'(w);
		return sum[FRAC_BITS +: HEIGHT_W];
	endfunction

	logic [1:0]          b_tl, b_tr, b_bl, b_br;
	logic [HEIGHT_W-1:0] top, bot;
	logic                en_out;

	logic                valid_s2, in_range_s2;
	logic [HEIGHT_W-1:0] top_s2, bot_s2;
	logic [FRAC_BITS-1:0] fy_s2;

	logic                out_valid_q, in_range_q;
	logic [HEIGHT_W-1:0] height_q;

	// Stall control: a stage loads when empty or when its successor moves
	assign en_out = !out_valid_q || out_ready;
	assign take   = !valid_s2 || en_out;

	// Undo the parity banking: pick the four neighbors
	assign b_tl = { ctl_s1.odd_row,  ctl_s1.odd_col};
	assign b_tr = { ctl_s1.odd_row, ~ctl_s1.odd_col};
	assign b_bl = {~ctl_s1.odd_row,  ctl_s1.odd_col};
	assign b_br = {~ctl_s1.odd_row, ~ctl_s1.odd_col};

	assign top = blend(cells_s1[b_tl], cells_s1[b_tr], fx_s1);
	assign bot = blend(cells_s1[b_bl], cells_s1[b_br], fx_s1);

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	// Stage 2 row blends
	always_ff @(posedge clk) begin
		if (take) begin
			in_range_s2 <= ctl_s1.in_range;
			top_s2      <= top;
			bot_s2      <= bot;
			fy_s2       <= fy_s1;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	// Output payload: column blend, zero outside the map
	always_ff @(posedge clk) begin
		if (en_out) begin
			in_range_q <= in_range_s2;
			height_q   <= in_range_s2 ? blend(top_s2, bot_s2, fy_s2) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_height   = height_q;
	assign out_in_range = in_range_q;

endmodule

### sv/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Square fixed-point height map with bilinear sampling at fractional points.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while responses are not stalled, writes and
//   samples mixed freely; the map is split into four banks by row and column
//   parity so a sample reads all four neighbors at once.
// Pipeline: each sample passes through the bank read, the row blend and the
//   column blend into the output register.
// Reset: clears the stage 1 control and the pipeline valid bits only; map cells are undefined until
//   written.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
	parameter int MAP_DIM   = MAP_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hbs_req_if.sink    req,
	hbs_rsp_if.source  rsp
);

	smp_ctl_t             ctl_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;
	logic [HEIGHT_W-1:0]  cells_s1 [NUM_BANKS];
	logic                 take;
	logic                 advance;
	logic                 accept;

	// Stage 1 moves when empty or drained into stage 2
	assign advance   = !ctl_s1.valid || take;
	assign req.ready = advance;
	assign accept    = req.valid && advance;

	hbs_fetch #(
		.MAP_DIM   (MAP_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_fetch (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.advance     (advance),
		.mode        (req.mode),
		.cell_row    (req.cell_row),
		.cell_col    (req.cell_col),
		.cell_height (req.cell_height),
		.x_pos       (req.x_pos),
		.y_pos       (req.y_pos),
		.ctl_s1      (ctl_s1),
		.fx_s1       (fx_s1),
		.fy_s1       (fy_s1),
		.cells_s1    (cells_s1)
	);

	hbs_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.fx_s1        (fx_s1),
		.fy_s1        (fy_s1),
		.cells_s1     (cells_s1),
		.take         (take),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_height   (rsp.height),
		.out_in_range (rsp.in_range)
	);

endmodule

### sim/heightmap_bilinear_sampler_test.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_test
// Self-checking bench for the height map sampler. A queue of cell writes and
// sample queries is streamed into the request channel with random gaps. Each
// request transfer updates a local copy of the map or predicts the sampled
// height. Every response transfer is checked against the oldest prediction.
// Samples only ever touch cells the bench has already written.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_test import hbs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_DIM    = MAP_DIM_DEF;
	localparam int FRAC_BITS  = FRAC_BITS_DEF;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int LIMIT      = (MAP_DIM - 1) * ONE;
	localparam int NUM_ITEMS  = 850;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 400;
	localparam int MAX_SHOWN  = 10;

	typedef struct {
		mode_t                     mode;
		logic [CELL_W-1:0]         row;
		logic [CELL_W-1:0]         col;
		logic [HEIGHT_W-1:0]       h;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} map_req_t;

	typedef struct {
		logic [HEIGHT_W-1:0] height;
		logic                in_range;
	} height_rsp_t;

	logic clk;
	logic arst_n;

	hbs_req_if req_ch ();
	hbs_rsp_if rsp_ch ();

	heightmap_bilinear_sampler #(
		.MAP_DIM   (MAP_DIM),
		.FRAC_BITS (FRAC_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Stimulus, generation-side bookkeeping
	map_req_t    pending_reqs[$];
	bit          cell_known[MAP_DIM*MAP_DIM];
	int          n_writes;
	int          n_in_samples;
	int          n_out_samples;

	// Prediction state and expected heights
	logic [HEIGHT_W-1:0] height_map[MAP_DIM*MAP_DIM];
	height_rsp_t         expected_heights[$];

	int  req_count;
	int  rsp_count;
	int  error_count;
	int  idle_cycles;
	int  hold_cnt;
	bit  hold_fired;
	bit  steady;
	int  phase_cnt;

	// ------------------------------------------------------------------
	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.mode        = MODE_WRITE;
		req_ch.cell_row    = '0;
		req_ch.cell_col    = '0;
		req_ch.cell_height = '0;
		req_ch.x_pos       = '0;
		req_ch.y_pos       = '0;
		rsp_ch.ready       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predictor
	function automatic int mix(int a, int b, int w);
		return (a * (ONE - w) + b * w) >> FRAC_BITS;
	endfunction

	function automatic height_rsp_t sample_height(logic signed [COORD_W-1:0] xp,
			logic signed [COORD_W-1:0] yp);
		int xs, ys, ix, iy, fx, fy, top, bot;
		height_rsp_t r;
		xs = xp;
		ys = yp;
		r.height   = '0;
		r.in_range = 1'b0;
		if (xs < 0 || xs >= LIMIT || ys < 0 || ys >= LIMIT)
			return r;
		ix = xs >> FRAC_BITS;
		iy = ys >> FRAC_BITS;
		fx = xs & (ONE - 1);
		fy = ys & (ONE - 1);
		top = mix(height_map[iy*MAP_DIM + ix], height_map[iy*MAP_DIM + ix + 1], fx);
		bot = mix(height_map[(iy+1)*MAP_DIM + ix], height_map[(iy+1)*MAP_DIM + ix + 1], fx);
		r.height   = HEIGHT_W'(mix(top, bot, fy));
		r.in_range = 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 92)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_write(int row, int col, int h);
		map_req_t it;
		it.mode = MODE_WRITE;
		it.row  = CELL_W'(row);
		it.col  = CELL_W'(col);
		it.h    = HEIGHT_W'(h);
		it.x    = COORD_W'($urandom);
		it.y    = COORD_W'($urandom);
		cell_known[row*MAP_DIM + col] = 1'b1;
		pending_reqs.push_back(it);
		n_writes++;
	endfunction

	// In-range samples first fill any unwritten neighbor with a random height
	function automatic void queue_sample(int x, int y);
		map_req_t it;
		int ix, iy;
		if (x >= 0 && x < LIMIT && y >= 0 && y < LIMIT) begin
			ix = x >> FRAC_BITS;
			iy = y >> FRAC_BITS;
			for (int dr = 0; dr < 2; dr++)
				for (int dc = 0; dc < 2; dc++)
					if (!cell_known[(iy+dr)*MAP_DIM + ix + dc])
						queue_write(iy + dr, ix + dc, $urandom_range(0, 4095));
			n_in_samples++;
		end else begin
			n_out_samples++;
		end
		it.mode = MODE_SAMPLE;
		it.row  = CELL_W'($urandom);
		it.col  = CELL_W'($urandom);
		it.h    = HEIGHT_W'($urandom);
		it.x    = COORD_W'(x);
		it.y    = COORD_W'(y);
		pending_reqs.push_back(it);
	endfunction

	function automatic int pick_frac();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return ONE - 1;
		return $urandom_range(0, ONE - 1);
	endfunction

	function automatic int pick_height();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 4095;
		return $urandom_range(0, 4095);
	endfunction

	// One coordinate off the map, the other anywhere
	function automatic void queue_off_map();
		int a, b;
		a = $urandom_range(0, 1) ? -$urandom_range(1, 65536) : $urandom_range(LIMIT, 65535);
		b = $urandom_range(0, 131071) - 65536;
		if ($urandom_range(0, 1))
			queue_sample(a, b);
		else
			queue_sample(b, a);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus: directed corners and edges, then random traffic
	initial begin
		int base_r, base_c, ix, iy, r;
		n_writes = 0;
		n_in_samples = 0;
		n_out_samples = 0;

		// top-left quad at full height: max fractions must not lose the top code
		queue_write(0, 0, 4095);
		queue_write(0, 1, 4095);
		queue_write(1, 0, 4095);
		queue_write(1, 1, 4095);
		queue_sample(ONE - 1, ONE - 1);
		queue_sample(0, 0);
		// bottom-right quad, last in-range point
		queue_write(MAP_DIM - 2, MAP_DIM - 2, 0);
		queue_write(MAP_DIM - 2, MAP_DIM - 1, 4095);
		queue_write(MAP_DIM - 1, MAP_DIM - 2, 4095);
		queue_write(MAP_DIM - 1, MAP_DIM - 1, 1);
		queue_sample(LIMIT - 1, LIMIT - 1);
		// just outside, both signs and field extremes, then one point inside
		queue_sample(LIMIT, 0);
		queue_sample(0, LIMIT);
		queue_sample(-1, 0);
		queue_sample(-65536, 65535);
		queue_sample(65535, -65536);
		queue_sample(ONE / 2, 0);
		// rewrite a cell and read it back at once
		queue_write(0, 0, 0);
		queue_sample(ONE / 2, ONE / 2);
		queue_sample(LIMIT - ONE, LIMIT - 1);

		base_r = 0;
		base_c = 0;
		while (pending_reqs.size() < NUM_ITEMS) begin
			if ($urandom_range(0, 39) == 0) begin
				base_r = $urandom_range(0, MAP_DIM - 10);
				base_c = $urandom_range(0, MAP_DIM - 10);
			end
			r = $urandom_range(0, 99);
			if (r < 30) begin
				if ($urandom_range(0, 1))
					queue_write($urandom_range(0, MAP_DIM - 1), $urandom_range(0, MAP_DIM - 1),
						pick_height());
				else
					queue_write(base_r + $urandom_range(0, 8), base_c + $urandom_range(0, 8),
						pick_height());
			end else if (r < 88) begin
				if ($urandom_range(0, 3) != 0) begin
					iy = base_r + $urandom_range(0, 7);
					ix = base_c + $urandom_range(0, 7);
				end else begin
					iy = $urandom_range(0, MAP_DIM - 2);
					ix = $urandom_range(0, MAP_DIM - 2);
				end
				queue_sample(ix * ONE + pick_frac(), iy * ONE + pick_frac());
			end else begin
				queue_off_map();
			end
		end
	end

	// ------------------------------------------------------------------
	// Steady phases: stretches with no random gaps on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady    <= 1'b0;
			phase_cnt <= 0;
		end else begin
			phase_cnt <= phase_cnt + 1;
			if (phase_cnt % 128 == 127)
				steady <= ($urandom_range(0, 3) == 0);
		end
	end

	// ------------------------------------------------------------------
	// Request driver
	int       drv_gap;
	map_req_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			drv_gap = 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (drv_gap > 0) begin
				drv_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				drv_item = pending_reqs.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.mode        <= drv_item.mode;
				req_ch.cell_row    <= drv_item.row;
				req_ch.cell_col    <= drv_item.col;
				req_ch.cell_height <= drv_item.h;
				req_ch.x_pos       <= drv_item.x;
				req_ch.y_pos       <= drv_item.y;
				drv_gap = (steady || $urandom_range(0, 1)) ? 0 : idle_len();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold-off once the stream is well under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt   <= 0;
			hold_fired <= 1'b0;
		end else if (!hold_fired && req_count >= HOLD_AT) begin
			hold_cnt   <= HOLD_LEN;
			hold_fired <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// ------------------------------------------------------------------
	// Response ready with random stalls
	int rcv_stall;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rcv_stall = 0;
		end else if (hold_cnt != 0) begin
			rsp_ch.ready <= 1'b0;
		end else if (rcv_stall > 0) begin
			rsp_ch.ready <= 1'b0;
			rcv_stall--;
		end else begin
			rsp_ch.ready <= 1'b1;
			rcv_stall = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on request transfers, check on response transfers
	always @(posedge clk) begin
		height_rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				req_count <= req_count + 1;
				if (req_ch.mode == MODE_WRITE) begin
					if (req_ch.cell_row < MAP_DIM && req_ch.cell_col < MAP_DIM)
						height_map[req_ch.cell_row*MAP_DIM + req_ch.cell_col] = req_ch.cell_height;
				end else begin
					expected_heights.push_back(sample_height(req_ch.x_pos, req_ch.y_pos));
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_count <= rsp_count + 1;
				if (expected_heights.size() == 0) begin
					error_count++;
					if (error_count <= MAX_SHOWN)
						$display("%0t: unexpected response height=%0d in_range=%0b",
							$realtime, rsp_ch.height, rsp_ch.in_range);
				end else begin
					want = expected_heights.pop_front();
					if (rsp_ch.height !== want.height || rsp_ch.in_range !== want.in_range) begin
						error_count++;
						if (error_count <= MAX_SHOWN)
							$display("%0t: response %0d: expected height=%0d in_range=%0b, got height=%0d in_range=%0b",
								$realtime, rsp_count, want.height, want.in_range,
								rsp_ch.height, rsp_ch.in_range);
					end
				end
			end
		end
	end

	initial begin
		req_count   = 0;
		rsp_count   = 0;
		error_count = 0;
	end

	// ------------------------------------------------------------------
	// Watchdog: no transfer on either channel for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// End of run
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		wait (pending_reqs.size() == 0 && req_count == n_writes + n_in_samples + n_out_samples
			&& expected_heights.size() == 0);
		// let any stray response surface
		repeat (20) @(posedge clk);
		if (expected_heights.size() != 0) begin
			error_count += expected_heights.size();
			$display("%0d expected responses never arrived", expected_heights.size());
		end
		$display("covered %0d cell writes, %0d on-map and %0d off-map samples",
			n_writes, n_in_samples, n_out_samples);
		$display("checked %0d responses, %0d errors", rsp_count, error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### heightmap_bilinear_sampler.f
sv/hbs_pkg.sv
sv/hbs_req_if.sv
sv/hbs_rsp_if.sv
sv/hbs_ram.sv
sv/hbs_fetch.sv
sv/hbs_interp.sv
sv/heightmap_bilinear_sampler.sv
sim/heightmap_bilinear_sampler_test.sv
